// ===== sv/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte hasher.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

    localparam logic [1:0] OP_ABSORB = 2'd0;
    localparam logic [1:0] OP_DIGEST = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [60:0] MAX_BYTES = {61{1'b1}};
    localparam int          QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } item_t;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] chain_t;

    localparam chain_t INIT_H = '{
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        begin
            unique case (idx)
                6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
                6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
                6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
                6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
                6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
                6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
                6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
                6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
                6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
                6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
                6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
                6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
                6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
                6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
                6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
                6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
                6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
                6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
                6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
                6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
                6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
                6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
                6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
                6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
                6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
                6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
                6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
                6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
                6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
                6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ===== sv/sha_item_queue.sv =====
// Front part: accept items and hold them in a short queue for the core.
// Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_item_queue
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       q_valid,
    input  logic       q_pop,
    output item_t      q_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    item_t         mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          push, pop;

    assign in_ready = (count_reg != (AW+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    // store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== sv/sha_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== sv/sha_core.sv =====
// Back part: run absorb, digest and clear items; one SHA-256 round per cycle.
// Depends on sha_pkg and sha_ram.
`timescale 1ns / 1ps

module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  item_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        length_fault
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    chain_t      chain_reg, scratch_reg;
    word_t [7:0] work_reg;
    word_t [15:0] w_reg;
    logic [5:0]  count_reg;
    logic [60:0] bytes_reg;
    logic        ovf_reg;
    logic [6:0]  step_reg;
    logic        digest_reg, second_reg, pad_two_reg;
    logic [5:0]  pad_n_reg;
    logic [2:0]  emit_idx_reg;

    logic        ram_we;
    logic [5:0]  ram_raddr;
    logic [7:0]  ram_rdata;
    logic [63:0] bits;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .clk(clk), .we(ram_we), .waddr(count_reg), .wdata(q_item.data_byte),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign bits = {bytes_reg, 3'b000};
    assign ram_we = (state_reg == S_IDLE) && q_valid && q_item.op == OP_ABSORB
                    && bytes_reg != MAX_BYTES;
    assign ram_raddr = step_reg[5:0];
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // byte of the block being loaded; step_reg-1 was addressed last cycle
    logic [5:0] ld_idx;
    logic [7:0] ld_byte;
    assign ld_idx = step_reg[5:0] - 6'd1;
    always_comb
    begin
        if (!digest_reg)
            ld_byte = ram_rdata;
        else if (!second_reg && ld_idx < pad_n_reg)
            ld_byte = ram_rdata;
        else if (!second_reg && ld_idx == pad_n_reg)
            ld_byte = 8'h80;
        else if (pad_two_reg && !second_reg)
            ld_byte = 8'h00;
        else if (ld_idx >= 6'd56)
            ld_byte = bits[8*(63-ld_idx) +: 8];
        else
            ld_byte = 8'h00;
    end

    // round datapath
    word_t s0, s1, wnew, t1, t2, wcur;
    word_t [7:0] v;
    always_comb
    begin
        v    = work_reg;
        wcur = w_reg[0];
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(step_reg[5:0]) + wcur;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    end

    // pick the next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if ((ram_we && count_reg == 6'd63) || (q_valid && q_item.op == OP_DIGEST))
                    state_next = S_LOAD;
            end
            S_LOAD:  if (step_reg == 7'd64) state_next = S_ROUND;
            S_ROUND: if (step_reg == 7'd63) state_next = S_ADD;
            S_ADD:
            begin
                if (!digest_reg)
                    state_next = S_IDLE;
                else if (pad_two_reg && !second_reg)
                    state_next = S_LOAD;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:  if (out_ready && emit_idx_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid    = (state_reg == S_EMIT);
    assign digest_word  = scratch_reg[emit_idx_reg];
    assign word_index   = emit_idx_reg;
    assign last_word    = (emit_idx_reg == 3'd7);
    assign length_fault = ovf_reg;

    // sequence absorb, compression and digest output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chain_reg    <= INIT_H;
            scratch_reg  <= '0;
            work_reg     <= '0;
            w_reg        <= '0;
            count_reg    <= '0;
            bytes_reg    <= '0;
            ovf_reg      <= 1'b0;
            step_reg     <= '0;
            digest_reg   <= 1'b0;
            second_reg   <= 1'b0;
            pad_two_reg  <= 1'b0;
            pad_n_reg    <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        unique case (q_item.op)
                            OP_ABSORB:
                            begin
                                if (bytes_reg == MAX_BYTES)
                                    ovf_reg <= 1'b1;
                                else
                                begin
                                    bytes_reg <= bytes_reg + 61'd1;
                                    count_reg <= count_reg + 6'd1;
                                    if (count_reg == 6'd63)
                                    begin
                                        digest_reg <= 1'b0;
                                        second_reg <= 1'b0;
                                        step_reg   <= '0;
                                    end
                                end
                            end
                            OP_DIGEST:
                            begin
                                digest_reg  <= 1'b1;
                                second_reg  <= 1'b0;
                                pad_n_reg   <= count_reg;
                                pad_two_reg <= (count_reg >= 6'd56);
                                step_reg    <= '0;
                            end
                            OP_CLEAR:
                            begin
                                chain_reg <= INIT_H;
                                count_reg <= '0;
                                bytes_reg <= '0;
                                ovf_reg   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    // shift in one byte; at start seed working words
                    if (step_reg == 7'd0)
                        work_reg <= (digest_reg && second_reg) ? scratch_reg : chain_reg;
                    if (step_reg == 7'd0 && digest_reg && !second_reg)
                        scratch_reg <= chain_reg;
                    if (step_reg != 7'd0)
                    begin
                        w_reg[ld_idx[5:2]] <= {w_reg[ld_idx[5:2]][23:0], ld_byte};
                    end
                    step_reg <= (step_reg == 7'd64) ? 7'd0 : step_reg + 7'd1;
                end
                S_ROUND:
                begin
                    work_reg <= {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
                    w_reg    <= {wnew, w_reg[15:1]};
                    step_reg <= step_reg + 7'd1;
                end
                S_ADD:
                begin
                    step_reg <= '0;
                    if (!digest_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                            chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                            scratch_reg[i] <= scratch_reg[i] + work_reg[i];
                        if (pad_two_reg && !second_reg)
                            second_reg <= 1'b1;
                        else
                            emit_idx_reg <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                        emit_idx_reg <= emit_idx_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/sha256_byte_stream_hasher_top.sv =====
// SHA-256 byte hasher: an absorb beat writes one byte into the block buffer; a full block
// then runs a load phase, 64 rounds (one round per cycle) and an add step.
// A digest runs one padding block (two when 56 or more bytes of the block are pending),
// then emits its eight words as output beats, which out_ready can stall.
// Items queue in a four-entry front queue while the core is busy.
// Asynchronous active-low reset restores initial chaining words and empties state.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_top
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        length_fault
);

    item_t in_item, q_item;
    logic  q_valid, q_pop;

    assign in_item = '{op: op, data_byte: data_byte};

    sha_item_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word), .length_fault(length_fault)
    );

endmodule

// ===== tb/sha256_byte_stream_hasher_top_test.sv =====
// Self-checking bench for the SHA-256 byte-stream hasher: random byte messages, digests, clears.
// Depends on sha_pkg and sha256_byte_stream_hasher_top; a scoreboard class holds the digest model.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_top_test
    import sha_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [31:0] RK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        lerr;
    } digest_beat_t;

    class digest_scoreboard;
        logic [31:0]  hash_words [8];
        logic [7:0]   block_bytes [64];
        logic [5:0]   fill;
        logic [60:0]  byte_total;
        logic         overflow;
        digest_beat_t pending_words [$];
        int           errors;

        function new();
            for (int i = 0; i < 8; i++) hash_words[i] = INIT_H[i];
            fill = '0;
            byte_total = '0;
            overflow = 1'b0;
            errors = 0;
        endfunction

        function logic [31:0] ror(input logic [31:0] v, input int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        // Fold one 64-byte block into the given chaining words
        function void fold(inout logic [31:0] h[8], input logic [7:0] blk[64]);
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            e = h[4]; f = h[5]; g = h[6]; hh = h[7];
            for (int i = 0; i < 64; i++)
            begin
                t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                     + RK[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
            h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        endfunction

        // Advance the model on one accepted input beat
        function void note_item(input logic [1:0] op_code, input logic [7:0] value);
            logic [31:0]  scratch [8];
            logic [7:0]   pad [64];
            logic [63:0]  bit_len;
            digest_beat_t beat;
            case (op_code)
                OP_ABSORB:
                begin
                    if (byte_total == MAX_BYTES)
                    begin
                        overflow = 1'b1;
                    end
                    else
                    begin
                        byte_total++;
                        block_bytes[fill] = value;
                        fill++;
                        if (fill == 0) fold(hash_words, block_bytes);
                    end
                end
                OP_DIGEST:
                begin
                    scratch = hash_words;
                    for (int i = 0; i < 64; i++) pad[i] = (i < fill) ? block_bytes[i] : 8'h00;
                    pad[fill] = 8'h80;
                    if (fill > 55)
                    begin
                        fold(scratch, pad);
                        for (int i = 0; i < 64; i++) pad[i] = 8'h00;
                    end
                    bit_len = {byte_total, 3'b000};
                    for (int i = 0; i < 8; i++) pad[56+i] = bit_len[8*(7-i) +: 8];
                    fold(scratch, pad);
                    for (int i = 0; i < 8; i++)
                    begin
                        beat.word = scratch[i];
                        beat.index = i[2:0];
                        beat.last = (i == 7);
                        beat.lerr = overflow;
                        pending_words.push_back(beat);
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < 8; i++) hash_words[i] = INIT_H[i];
                    fill = '0;
                    byte_total = '0;
                    overflow = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // Compare one output beat with the oldest expected word
        function void check_word(input logic [31:0] w, input logic [2:0] idx,
                                 input logic lw, input logic le);
            digest_beat_t exp_beat;
            if (pending_words.size() == 0)
            begin
                $error("unexpected digest beat word=%h index=%0d", w, idx);
                errors++;
                return;
            end
            exp_beat = pending_words.pop_front();
            if (w !== exp_beat.word)
            begin
                $error("digest_word expected %h actual %h", exp_beat.word, w);
                errors++;
            end
            if (idx !== exp_beat.index)
            begin
                $error("word_index expected %0d actual %0d", exp_beat.index, idx);
                errors++;
            end
            if (lw !== exp_beat.last)
            begin
                $error("last_word expected %b actual %b", exp_beat.last, lw);
                errors++;
            end
            if (le !== exp_beat.lerr)
            begin
                $error("length_fault expected %b actual %b", exp_beat.lerr, le);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_fault;

    digest_scoreboard sb = new();
    int  idle_cycles = 0;
    int  items_sent = 0;
    bit  calm_phase = 0;

    sha256_byte_stream_hasher_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index),
        .last_word(last_word), .length_fault(length_fault)
    );

    always #10 clk = ~clk;

    // Pick a gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm_phase) return 0;
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Send one beat, holding valid until the block accepts it
    task automatic send_item(input logic [1:0] op_code, input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= op_code;
        data_byte <= value;
        do @(posedge clk); while (!in_ready);
        sb.note_item(op_code, value);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
    endtask

    // Wait until every expected digest beat has come back
    task automatic drain_results();
        while (sb.pending_words.size() != 0) @(negedge clk);
    endtask

    // Stall the result side at random
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Check result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(digest_word, word_index, last_word, length_fault);
    end

    // Count cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int pick;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty digest, unused op, byte extremes, clear, data ignored on digest
        send_item(OP_DIGEST, 8'hFF);
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_DIGEST, 8'h00);
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_ABSORB, 8'hFF);
        send_item(OP_DIGEST, 8'h5A);
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_DIGEST, 8'h00);
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_DIGEST, 8'h00);
        send_item(OP_ABSORB, 8'h80);
        send_item(OP_ABSORB, 8'h7F);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_ABSORB, 8'h01);
        send_item(OP_DIGEST, 8'h00);

        // Hold off until every digest beat is back
        in_valid <= 1'b0;
        drain_results();

        // Random messages, lengths clustered at the padding boundaries
        while (items_sent < 200)
        begin
            calm_phase = ($urandom_range(3) == 0);
            pick = $urandom_range(9);
            if (pick < 4) send_message($urandom_range(10));
            else if (pick < 6) send_message($urandom_range(57, 54));
            else if (pick < 8) send_message($urandom_range(65, 62));
            else send_message($urandom_range(40, 11));
            pick = $urandom_range(9);
            if (pick < 7) send_item(OP_DIGEST, 8'($urandom));
            if (pick == 0) send_item(OP_UNUSED, 8'($urandom));
            if ($urandom_range(4) == 0) send_item(OP_CLEAR, 8'($urandom));
        end
        calm_phase = 0;
        in_valid <= 1'b0;

        // Drain and let any block compression finish
        drain_results();
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
